@@ rtl/mptp_pkg.sv @@
// Package for the mesh point tag promotion block: sizes, codes and the
// structures passed between front end, queue and back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mptp_pkg;

	// Sizes of the tag store and the element counters
	localparam int POINT_DEPTH  = 65536;
	localparam int VERTEX_LIMIT = 1048576;
	localparam int PT_AW        = $clog2(POINT_DEPTH);
	localparam int VCNT_W       = $clog2(VERTEX_LIMIT);

	// Fixed field widths
	localparam int PIDX_W    = 16;
	localparam int TOTAL_W   = 17;
	localparam int OUT_IDX_W = 20;

	// Queue between front and back end
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_VERTEX = 1'b1;

	// Output kinds
	localparam logic [1:0] KIND_FACE_VERTEX = 2'd0;
	localparam logic [1:0] KIND_POINT       = 2'd1;
	localparam logic [1:0] KIND_FACE        = 2'd2;
	localparam logic [1:0] KIND_HALF_EDGE   = 2'd3;

	// Reductions
	localparam logic OP_AND = 1'b0;
	localparam logic OP_OR  = 1'b1;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_OUT_KIND    = 2'd0;
	localparam logic [1:0] REG_COMBINE_OP  = 2'd1;
	localparam logic [1:0] REG_POINT_TOTAL = 2'd2;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic               combine_op;
		logic [TOTAL_W-1:0] point_total;
	} cfg_t;

	// A classified item: tag already looked up (or taken from a load), range checked
	typedef struct packed {
		logic              mode;
		logic [PIDX_W-1:0] point_index;
		logic              tag;
		logic              last_in_face;
		logic              err;
	} entry_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] out_index;
		logic                 out_tag;
		logic                 error;
		logic                 last;
	} result_t;

	function automatic logic combine(input logic op, input logic a, input logic b);
		combine = (op == OP_OR) ? (a | b) : (a & b);
	endfunction

	function automatic logic [VCNT_W-1:0] bump(input logic [VCNT_W-1:0] c);
		bump = (c == VCNT_W'(VERTEX_LIMIT - 1)) ? '0 : c + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/mesh_point_tag_promote_top.sv @@
// Top level of the mesh point tag promotion block: stream ports, register
// port and the front end, queue and back end. Uses mptp_pkg, mptp_front, mptp_fifo and mptp_back.
`timescale 1ns / 1ps
`default_nettype none
// Promotes one-bit point tags of a polygon mesh to vertices, points, faces or
// half-edges. Load beats (tuser 0) write a point tag; vertex beats (tuser 1)
// stream in polygon order with tlast closing each face. After reset the tag
// store is swept to zero, during which s_tready stays low; register writes
// are taken throughout. The front end accepts one beat per clock while the
// queue has room, and does a single tag store access for it; the back end
// sends at most one result per clock through a single output register. A
// beat yields at most one result, except a half-edge face closer that yields
// two results in turn; each result passes through the read stage, the queue
// and the output register. A four-entry queue lets the input keep running
// while the output stalls briefly.
// Registers (byte address): 0x0 out_kind, 0x4 combine_op, 0x8 point_total.
// They should only be written while no beat is in flight.
module mesh_point_tag_promote_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // [15:0] point_index, [16] tag_value, [23:17] zero
	input  wire logic        s_tuser,  // [0] mode
	input  wire logic        s_tlast,  // last_in_face
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [19:0] out_index, [20] out_tag, [23:21] zero
	output logic             m_tuser,  // [0] error
	output logic             m_tlast,  // last result of the beat
	// Register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mptp_pkg::*;

	cfg_t               cfg_q;
	logic               cfg_we;
	logic               push;
	entry_t             push_entry;
	logic               pop;
	logic               head_valid;
	entry_t             head;
	logic [FIFO_AW:0]   fifo_count;
	result_t            res;

	// Register block: zero wait states, written in the access phase
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_kind    <= KIND_FACE_VERTEX;
			cfg_q.combine_op  <= OP_AND;
			cfg_q.point_total <= '0;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				REG_OUT_KIND:    cfg_q.out_kind    <= pwdata[1:0];
				REG_COMBINE_OP:  cfg_q.combine_op  <= pwdata[0];
				REG_POINT_TOTAL: cfg_q.point_total <= pwdata[TOTAL_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OUT_KIND:    prdata = {30'd0, cfg_q.out_kind};
			REG_COMBINE_OP:  prdata = {31'd0, cfg_q.combine_op};
			REG_POINT_TOTAL: prdata = {15'd0, cfg_q.point_total};
			default:         prdata = 32'd0;
		endcase
	end

	mptp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (s_tuser),
		.in_pidx    (s_tdata[15:0]),
		.in_tag     (s_tdata[16]),
		.in_last    (s_tlast),
		.fifo_count (fifo_count),
		.push       (push),
		.push_entry (push_entry)
	);

	mptp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (fifo_count)
	);

	mptp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	assign m_tdata = {3'd0, res.out_tag, res.out_index};
	assign m_tuser = res.error;
	assign m_tlast = res.last;

endmodule
`default_nettype wire

@@ rtl/mptp_front.sv @@
// Front end: accepts items, checks the point index, owns the tag store with
// its clearing pass, and hands classified items to the queue. Uses mptp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptp_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire mptp_pkg::cfg_t                   cfg,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             in_mode,
	input  wire logic [mptp_pkg::PIDX_W-1:0]      in_pidx,
	input  wire logic                             in_tag,
	input  wire logic                             in_last,
	input  wire logic [mptp_pkg::FIFO_AW:0]       fifo_count,
	output logic                                  push,
	output mptp_pkg::entry_t                      push_entry
);
	import mptp_pkg::*;

	logic              mem [POINT_DEPTH];
	logic              rd_q;
	logic              clearing_q;
	logic [PT_AW-1:0]  clr_addr_q;
	logic              s1_valid_q;
	logic              s1_mode_s1;
	logic [PIDX_W-1:0] s1_pidx_s1;
	logic              s1_tag_s1;
	logic              s1_last_s1;
	logic              s1_ok_s1;
	logic              accept;
	logic              ok;
	logic              mem_we;
	logic [PT_AW-1:0]  mem_addr;

	// Space is reserved for the item already in the read stage
	assign in_ready = !clearing_q
		&& ((32'(fifo_count) + 32'(s1_valid_q)) < FIFO_DEPTH);
	assign accept   = in_valid && in_ready;
	assign ok       = ({1'b0, in_pidx} < cfg.point_total) && (32'(in_pidx) < POINT_DEPTH);
	assign mem_we   = clearing_q || (accept && (in_mode == MODE_LOAD) && ok);
	assign mem_addr = clearing_q ? clr_addr_q : PT_AW'(in_pidx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == PT_AW'(POINT_DEPTH - 1))
					clearing_q <= 1'b0;
			end
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= clearing_q ? 1'b0 : in_tag;
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_mode_s1 <= in_mode;
			s1_pidx_s1 <= in_pidx;
			s1_tag_s1  <= in_tag;
			s1_last_s1 <= in_last;
			s1_ok_s1   <= ok;
		end
	end

	always_comb begin
		push                    = s1_valid_q;
		push_entry.mode         = s1_mode_s1;
		push_entry.point_index  = s1_pidx_s1;
		push_entry.last_in_face = s1_last_s1;
		push_entry.err          = !s1_ok_s1;
		if (!s1_ok_s1)
			push_entry.tag = 1'b0;
		else if (s1_mode_s1 == MODE_VERTEX)
			push_entry.tag = rd_q;
		else
			push_entry.tag = s1_tag_s1;
	end

endmodule
`default_nettype wire

@@ rtl/mptp_fifo.sv @@
// Short queue of classified items between front and back end.
// Uses mptp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptp_fifo (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire mptp_pkg::entry_t           push_entry,
	input  wire logic                       pop,
	output logic                            head_valid,
	output mptp_pkg::entry_t                head,
	output logic [mptp_pkg::FIFO_AW:0]      count
);
	import mptp_pkg::*;

	entry_t             slots [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_pop;

	assign head_valid = (count_q != '0);
	assign head       = slots[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots[wr_ptr_q] <= push_entry;
	end

endmodule
`default_nettype wire

@@ rtl/mptp_back.sv @@
// Back end: tracks faces and half-edges, forms up to two results per item and
// drives the output register. Uses mptp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptp_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mptp_pkg::cfg_t   cfg,
	input  wire logic             head_valid,
	input  wire mptp_pkg::entry_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mptp_pkg::result_t     out_res
);
	import mptp_pkg::*;

	logic [VCNT_W-1:0] vcnt_q;
	logic [VCNT_W-1:0] fcnt_q;
	logic [VCNT_W-1:0] prev_idx_q;
	logic              first_tag_q;
	logic              first_err_q;
	logic              prev_tag_q;
	logic              prev_err_q;
	logic              inside_q;
	logic              acc_q;
	logic              ferr_q;
	logic              phase_q;
	logic              out_valid_q;
	result_t           out_q;

	logic    is_vtx;
	logic    acc_n;
	logic    ferr_n;
	logic    first_tag_n;
	logic    first_err_n;
	logic    has_a;
	logic    has_b;
	logic    sel_a;
	logic    out_free;
	logic    emit;
	result_t res_a;
	result_t res_b;
	result_t res_sel;

	always_comb begin
		is_vtx      = (head.mode == MODE_VERTEX);
		acc_n       = inside_q ? combine(cfg.combine_op, acc_q, head.tag) : head.tag;
		ferr_n      = inside_q ? (ferr_q | head.err) : head.err;
		first_tag_n = inside_q ? first_tag_q : head.tag;
		first_err_n = inside_q ? first_err_q : head.err;

		// Edge that the previous vertex opened, closed by this one
		has_a           = is_vtx && inside_q && (cfg.out_kind == KIND_HALF_EDGE);
		res_a.out_index = OUT_IDX_W'(prev_idx_q);
		res_a.out_tag   = combine(cfg.combine_op, prev_tag_q, head.tag);
		res_a.error     = prev_err_q | head.err;
		res_a.last      = 1'b0;

		has_b           = 1'b0;
		res_b.out_index = OUT_IDX_W'(vcnt_q);
		res_b.out_tag   = head.tag;
		res_b.error     = head.err;
		res_b.last      = 1'b1;
		if (!is_vtx) begin
			has_b           = (cfg.out_kind == KIND_POINT);
			res_b.out_index = OUT_IDX_W'(head.point_index);
		end else begin
			case (cfg.out_kind)
				KIND_FACE_VERTEX: has_b = 1'b1;
				KIND_FACE: begin
					has_b           = head.last_in_face;
					res_b.out_index = OUT_IDX_W'(fcnt_q);
					res_b.out_tag   = acc_n;
					res_b.error     = ferr_n;
				end
				KIND_HALF_EDGE: begin
					// Closing edge wraps back to the face's first vertex
					has_b         = head.last_in_face;
					res_b.out_tag = combine(cfg.combine_op, head.tag, first_tag_n);
					res_b.error   = head.err | first_err_n;
				end
				default: has_b = 1'b0;
			endcase
		end

		sel_a    = has_a && !phase_q;
		out_free = !out_valid_q || out_ready;
		emit     = head_valid && (sel_a || has_b) && out_free;
		res_sel  = sel_a ? res_a : res_b;
		if (sel_a)
			res_sel.last = !has_b;
		pop = head_valid && (!(sel_a || has_b) || (emit && res_sel.last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			fcnt_q      <= '0;
			prev_idx_q  <= '0;
			first_tag_q <= 1'b0;
			first_err_q <= 1'b0;
			prev_tag_q  <= 1'b0;
			prev_err_q  <= 1'b0;
			inside_q    <= 1'b0;
			acc_q       <= 1'b0;
			ferr_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (pop)
				phase_q <= 1'b0;
			else if (emit && sel_a)
				phase_q <= 1'b1;

			if (pop && is_vtx) begin
				acc_q       <= acc_n;
				ferr_q      <= ferr_n;
				first_tag_q <= first_tag_n;
				first_err_q <= first_err_n;
				prev_tag_q  <= head.tag;
				prev_err_q  <= head.err;
				prev_idx_q  <= vcnt_q;
				vcnt_q      <= bump(vcnt_q);
				inside_q    <= !head.last_in_face;
				if (head.last_in_face)
					fcnt_q <= bump(fcnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res_sel;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

@@ rtl/mptp_checker.sv @@
// Port-level checker for the mesh point tag promotion block, bound to its top
// level. Depends on mesh_point_tag_promote_top through its ports and on mptp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser,
	input wire logic        m_tlast,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready
);
	import mptp_pkg::*;

	logic [31:0] in_cnt_q;
	logic [31:0] closed_cnt_q;

	// Beats taken, and results that closed a beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q     <= '0;
			closed_cnt_q <= '0;
		end else begin
			if (s_tvalid && s_tready)
				in_cnt_q <= in_cnt_q + 1'b1;
			if (m_tvalid && m_tready && m_tlast)
				closed_cnt_q <= closed_cnt_q + 1'b1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_closed_by_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |-> closed_cnt_q < in_cnt_q)
		else $error("closing result with no beat behind it");

	a_kind_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[3:2] == REG_OUT_KIND)
		|=> (paddr[3:2] != REG_OUT_KIND) || (prdata[1:0] == $past(pwdata[1:0])))
		else $error("out_kind register does not read back");

	a_total_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[3:2] == REG_POINT_TOTAL)
		|=> (paddr[3:2] != REG_POINT_TOTAL) || (prdata[16:0] == $past(pwdata[16:0])))
		else $error("point_total register does not read back");

endmodule

bind mesh_point_tag_promote_top mptp_checker u_mptp_checker (.*);
`default_nettype wire
